@@ sv/r2h_pkg.sv @@
// Package for the RGB to HSV converter: field widths, fixed-point hue constants,
// hue sector codes and the sideband structs that ride along the divider pipeline.
// No dependencies.
`default_nettype none

package r2h_pkg;

    localparam int IN_W   = 8;    // width of one color channel field
    localparam int HUE_W  = 15;   // hue in 1/64 degree
    localparam int SAT_W  = 8;
    localparam int BRT_W  = 8;

    // 60 degrees in 1/64 degree units, and a full turn
    localparam int HUE_SECTOR = 3840;
    localparam int HUE_FULL   = 23040;
    localparam int SAT_SCALE  = 255;

    // quotient bits of both dividers: covers 0..HUE_SECTOR and 0..SAT_SCALE
    localparam int QUO_W = 12;

    // signed working width for the final hue sum
    localparam int HUE_SUM_W = 16;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    typedef struct packed {
        sector_t sector;
        logic    neg;      // sector difference below zero
    } hue_side_t;

    typedef struct packed {
        logic [BRT_W-1:0] brightness;
        logic             achro;
    } pix_side_t;

endpackage

`default_nettype wire

@@ sv/r2h_prep.sv @@
// Front stage of the RGB to HSV converter: max, min, delta, hue sector and the
// two dividends, registered. Depends on r2h_pkg.
`default_nettype none

module r2h_prep #(
    parameter int CB = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [r2h_pkg::IN_W-1:0]      red,
    input  wire logic [r2h_pkg::IN_W-1:0]      green,
    input  wire logic [r2h_pkg::IN_W-1:0]      blue,
    output logic                               out_valid,
    output logic [CB-1:0]                      delta,
    output logic [CB-1:0]                      max_val,
    output logic [CB+r2h_pkg::QUO_W-1:0]       hue_num,
    output logic [CB+r2h_pkg::QUO_W-1:0]       sat_num,
    output r2h_pkg::hue_side_t                 hue_side,
    output r2h_pkg::pix_side_t                 pix_side
);
    import r2h_pkg::*;

    localparam int NUM_W = CB + QUO_W;

    logic [CB+IN_W-1:0] r_ext, g_ext, b_ext;
    logic [CB-1:0]      r, g, b, mx, mn, d, mag;
    logic [CB+BRT_W-1:0] mx_ext;
    logic               neg;
    sector_t            sec;
    logic [NUM_W-1:0]   hue_num_next, sat_num_next;

    logic               valid_reg;
    logic [CB-1:0]      delta_reg, max_reg;
    logic [NUM_W-1:0]   hue_num_reg, sat_num_reg;
    hue_side_t          hue_side_reg;
    pix_side_t          pix_side_reg;

    always_comb
    begin
        // fit each channel field to the working channel width
        r_ext = {{CB{1'b0}}, red};
        g_ext = {{CB{1'b0}}, green};
        b_ext = {{CB{1'b0}}, blue};
        r = r_ext[CB-1:0];
        g = g_ext[CB-1:0];
        b = b_ext[CB-1:0];

        mx = (r > g) ? r : g;
        mn = (r < g) ? r : g;
        if (b > mx)
        begin
            mx = b;
        end
        if (b < mn)
        begin
            mn = b;
        end
        d = mx - mn;

        // ties go to red first, then green
        if (r >= mx)
        begin
            sec = SEC_RED;
            neg = (g < b);
            mag = neg ? (b - g) : (g - b);
        end
        else if (g >= mx)
        begin
            sec = SEC_GREEN;
            neg = (b < r);
            mag = neg ? (r - b) : (b - r);
        end
        else
        begin
            sec = SEC_BLUE;
            neg = (r < g);
            mag = neg ? (g - r) : (r - g);
        end

        hue_num_next = NUM_W'(mag) * NUM_W'(HUE_SECTOR);
        sat_num_next = NUM_W'(d) * NUM_W'(SAT_SCALE);
        mx_ext       = {{BRT_W{1'b0}}, mx};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            delta_reg               <= d;
            max_reg                 <= mx;
            hue_num_reg             <= hue_num_next;
            sat_num_reg             <= sat_num_next;
            hue_side_reg.sector     <= sec;
            hue_side_reg.neg        <= neg;
            pix_side_reg.brightness <= mx_ext[BRT_W-1:0];
            pix_side_reg.achro      <= (d == '0);
        end
    end

    assign out_valid = valid_reg;
    assign delta     = delta_reg;
    assign max_val   = max_reg;
    assign hue_num   = hue_num_reg;
    assign sat_num   = sat_num_reg;
    assign hue_side  = hue_side_reg;
    assign pix_side  = pix_side_reg;

endmodule

`default_nettype wire

@@ sv/r2h_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage, with a
// sideband vector that travels in step with the data. No package dependency.
`default_nettype none

module r2h_div #(
    parameter int DEN_W  = 8,
    parameter int QUO_W  = 12,
    parameter int SIDE_W = 1
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire logic [DEN_W+QUO_W-1:0]   num,    // must stay below den * 2**QUO_W
    input  wire logic [DEN_W-1:0]         den,
    input  wire logic [SIDE_W-1:0]        side_in,
    output logic                          out_valid,
    output logic [QUO_W-1:0]              quo,
    output logic                          rem_nz,
    output logic [SIDE_W-1:0]             side_out
);

    localparam int NUM_W = DEN_W + QUO_W;

    wire [NUM_W-1:0]  rem_s  [QUO_W+1];
    wire [QUO_W-1:0]  quo_s  [QUO_W+1];
    wire [DEN_W-1:0]  den_s  [QUO_W+1];
    wire [SIDE_W-1:0] side_s [QUO_W+1];
    wire              vld_s  [QUO_W+1];

    assign rem_s[0]  = num;
    assign quo_s[0]  = '0;
    assign den_s[0]  = den;
    assign side_s[0] = side_in;
    assign vld_s[0]  = in_valid;

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int BIT = QUO_W - 1 - k;

        logic [NUM_W-1:0]  sden;
        logic              take;
        logic [NUM_W-1:0]  rem_next;
        logic [QUO_W-1:0]  quo_next;

        logic [NUM_W-1:0]  rem_reg;
        logic [QUO_W-1:0]  quo_reg;
        logic [DEN_W-1:0]  den_reg;
        logic [SIDE_W-1:0] side_reg;
        logic              vld_reg;

        always_comb
        begin
            sden     = NUM_W'(den_s[k]) << BIT;
            take     = (rem_s[k] >= sden);
            rem_next = take ? (rem_s[k] - sden) : rem_s[k];
            quo_next = quo_s[k] | (QUO_W'(take) << BIT);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= vld_s[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                quo_reg  <= quo_next;
                den_reg  <= den_s[k];
                side_reg <= side_s[k];
            end
        end

        assign rem_s[k+1]  = rem_reg;
        assign quo_s[k+1]  = quo_reg;
        assign den_s[k+1]  = den_reg;
        assign side_s[k+1] = side_reg;
        assign vld_s[k+1]  = vld_reg;
    end

    assign out_valid = vld_s[QUO_W];
    assign quo       = quo_s[QUO_W];
    assign rem_nz    = |rem_s[QUO_W];
    assign side_out  = side_s[QUO_W];

endmodule

`default_nettype wire

@@ sv/r2h_fix.sv @@
// Back stage of the RGB to HSV converter: floor of negative sector values,
// sector offset, wrap into one turn, achromatic override, output register.
// Depends on r2h_pkg.
`default_nettype none

module r2h_fix (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [r2h_pkg::QUO_W-1:0]     hue_quo,
    input  wire logic                          hue_rem_nz,
    input  wire r2h_pkg::hue_side_t            hue_side,
    input  wire logic [r2h_pkg::QUO_W-1:0]     sat_quo,
    input  wire r2h_pkg::pix_side_t            pix_side,
    output logic                               out_valid,
    output logic [r2h_pkg::HUE_W-1:0]          hue,
    output logic [r2h_pkg::SAT_W-1:0]          saturation,
    output logic [r2h_pkg::BRT_W-1:0]          brightness,
    output logic                               achromatic
);
    import r2h_pkg::*;

    logic signed [HUE_SUM_W-1:0] off, mag, sum;
    logic [HUE_W-1:0]            hue_next;
    logic [SAT_W-1:0]            sat_next;

    logic                        valid_reg;
    logic [HUE_W-1:0]            hue_reg;
    logic [SAT_W-1:0]            sat_reg;
    logic [BRT_W-1:0]            brt_reg;
    logic                        achro_reg;

    always_comb
    begin
        case (hue_side.sector)
            SEC_RED:   off = '0;
            SEC_GREEN: off = HUE_SUM_W'(2 * HUE_SECTOR);
            SEC_BLUE:  off = HUE_SUM_W'(4 * HUE_SECTOR);
            default:   off = '0;
        endcase

        // a negative quotient floors one further down when the division was inexact
        mag = $signed(HUE_SUM_W'(hue_quo));
        if (hue_side.neg)
        begin
            sum = off - mag - $signed(HUE_SUM_W'(hue_rem_nz));
        end
        else
        begin
            sum = off + mag;
        end
        if (sum < 0)
        begin
            sum = sum + $signed(HUE_SUM_W'(HUE_FULL));
        end

        if (pix_side.achro)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = sum[HUE_W-1:0];
            sat_next = sat_quo[SAT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            brt_reg   <= pix_side.brightness;
            achro_reg <= pix_side.achro;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = brt_reg;
    assign achromatic = achro_reg;

endmodule

`default_nettype wire

@@ sv/rgb_to_hsv_converter_unit.sv @@
// Top level of the RGB to HSV converter: stream ports, pipeline enable and the
// front stage, the two dividers and the back stage. Depends on r2h_pkg,
// r2h_prep, r2h_div and r2h_fix.
`default_nettype none

// The converter takes one pixel word per clock while not stalled and returns
// one HSV word per pixel, in order, after the max/min/delta front stage, the
// restoring dividers (one quotient bit per register stage, hue and saturation
// dividing side by side) and the final hue fixup and output register.
// Throughput is one pixel per cycle with no gaps while the master side takes
// every word. The whole pipeline advances together whenever the output register
// is empty or being taken; a stall on the master side holds every stage, so
// s_tready follows m_tready combinationally. Hue is in 1/64 degree
// (0..23039), saturation is floor(255*delta/max), brightness is the largest
// channel, and a pixel whose channels are all equal comes out with hue and
// saturation zero and the achromatic flag set in m_tuser.
module rgb_to_hsv_converter_unit #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,    // red [7:0], green [15:8], blue [23:16]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // hue [14:0], saturation [22:15],
                                         // brightness [30:23], zero [31]
    output logic [0:0]       m_tuser     // achromatic [0]
);
    import r2h_pkg::*;

    localparam int NUM_W = CHANNEL_BITS + QUO_W;

    // pipeline-wide advance: output register free or being drained
    logic                    en;

    logic                    prep_valid;
    logic [CHANNEL_BITS-1:0] prep_delta;
    logic [CHANNEL_BITS-1:0] prep_max;
    logic [NUM_W-1:0]        prep_hue_num;
    logic [NUM_W-1:0]        prep_sat_num;
    hue_side_t               prep_hue_side;
    pix_side_t               prep_pix_side;

    logic                    hdiv_valid;
    logic [QUO_W-1:0]        hdiv_quo;
    logic                    hdiv_rem_nz;
    logic [$bits(hue_side_t)-1:0] hdiv_side;

    logic                    sdiv_valid;
    logic [QUO_W-1:0]        sdiv_quo;
    logic                    sdiv_rem_nz;
    logic [$bits(pix_side_t)-1:0] sdiv_side;

    logic [HUE_W-1:0]        hue;
    logic [SAT_W-1:0]        saturation;
    logic [BRT_W-1:0]        brightness;
    logic                    achromatic;
    logic                    out_valid;

    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    r2h_prep #(
        .CB (CHANNEL_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .out_valid (prep_valid),
        .delta     (prep_delta),
        .max_val   (prep_max),
        .hue_num   (prep_hue_num),
        .sat_num   (prep_sat_num),
        .hue_side  (prep_hue_side),
        .pix_side  (prep_pix_side)
    );

    // hue: 3840*|diff| / delta, sector info rides along
    r2h_div #(
        .DEN_W  (CHANNEL_BITS),
        .QUO_W  (QUO_W),
        .SIDE_W ($bits(hue_side_t))
    ) u_hue_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .num       (prep_hue_num),
        .den       (prep_delta),
        .side_in   (prep_hue_side),
        .out_valid (hdiv_valid),
        .quo       (hdiv_quo),
        .rem_nz    (hdiv_rem_nz),
        .side_out  (hdiv_side)
    );

    // saturation: 255*delta / max, brightness and achromatic ride along;
    // a zero divisor only happens for achromatic pixels, which the back stage overrides
    r2h_div #(
        .DEN_W  (CHANNEL_BITS),
        .QUO_W  (QUO_W),
        .SIDE_W ($bits(pix_side_t))
    ) u_sat_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .num       (prep_sat_num),
        .den       (prep_max),
        .side_in   (prep_pix_side),
        .out_valid (sdiv_valid),
        .quo       (sdiv_quo),
        .rem_nz    (sdiv_rem_nz),
        .side_out  (sdiv_side)
    );

    // both dividers march in lockstep; the saturation remainder is not needed
    r2h_fix u_fix (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (hdiv_valid & sdiv_valid),
        .hue_quo    (hdiv_quo),
        .hue_rem_nz (hdiv_rem_nz),
        .hue_side   (hue_side_t'(hdiv_side)),
        .sat_quo    (sdiv_quo | {{(QUO_W-1){1'b0}}, 1'b0 & sdiv_rem_nz}),
        .pix_side   (pix_side_t'(sdiv_side)),
        .out_valid  (out_valid),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .achromatic (achromatic)
    );

    assign m_tvalid   = out_valid;
    assign m_tdata    = {1'b0, brightness, saturation, hue};
    assign m_tuser[0] = achromatic;

endmodule

`default_nettype wire
